// ----- rtl/tbeic_pkg.sv -----
// Shared types, codes and constants for the two-bank edge interrupt controller.
// No dependencies; imported by tbeic_core and the top level.
package tbeic_pkg;

    localparam int WORD_W     = 32;
    localparam int BANK_WIDTH = 32;
    localparam int NUM_SRC    = 2 * WORD_W;
    localparam int GRP_W      = 8;
    localparam int NUM_GRP    = NUM_SRC / GRP_W;
    localparam int GRP_IDX_W  = $clog2(GRP_W);
    localparam int SRC_IDX_W  = $clog2(NUM_SRC);

    localparam logic [WORD_W-1:0]  BANK_MASK = WORD_W'((64'd1 << BANK_WIDTH) - 64'd1);
    localparam logic [NUM_SRC-1:0] IMPL_MASK = {BANK_MASK, BANK_MASK};

    // operation codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;

    // reg_select bit meanings
    localparam int SEL_BANK_BIT   = 0;  // 1 selects the high bank
    localparam int SEL_ENABLE_BIT = 1;  // 1 selects enable, 0 status

    // configuration register indexes
    localparam logic CFG_POL_LOW  = 1'b0;
    localparam logic CFG_POL_HIGH = 1'b1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [1:0]         reg_select;
        logic [WORD_W-1:0]  write_data;
        logic [NUM_SRC-1:0] source_levels;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic              index;
        logic [WORD_W-1:0] data;
    } cfg_wr_t;

    // first-stage result: read word plus per-group pending summary
    typedef struct packed {
        logic [WORD_W-1:0]                  read_data;
        logic [NUM_GRP-1:0]                 grp_any;
        logic [NUM_GRP-1:0][GRP_IDX_W-1:0]  grp_idx;
    } scan_t;

    // lowest set bit within one group; zero when the group is empty
    function automatic logic [GRP_IDX_W-1:0] lowest_in_group(input logic [GRP_W-1:0] v);
        logic [GRP_IDX_W-1:0] idx;
        idx = '0;
        for (int i = GRP_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = GRP_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- rtl/tbeic_core.sv -----
// Controller state: status, enable, previous active level and polarity,
// with the per-transaction update and the first level of the pending scan.
// Depends on tbeic_pkg.
module tbeic_core
    import tbeic_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_accept,
    input  item_t   item,
    input  cfg_wr_t cfg_wr,
    output scan_t   scan
);

    logic [NUM_SRC-1:0] status_reg, status_next;
    logic [NUM_SRC-1:0] enable_reg, enable_next;
    logic [NUM_SRC-1:0] prev_active_reg, prev_active_next;
    logic [WORD_W-1:0]  pol_low_reg, pol_high_reg;

    logic [NUM_SRC-1:0] active;
    logic [NUM_SRC-1:0] wmask;
    logic [NUM_SRC-1:0] wdata_sh;
    logic [WORD_W-1:0]  wdata;
    logic [WORD_W-1:0]  rd;
    logic               high;
    logic               en_sel;

    always_comb
    begin
        high     = item.reg_select[SEL_BANK_BIT];
        en_sel   = item.reg_select[SEL_ENABLE_BIT];
        wdata    = item.write_data & BANK_MASK;
        wdata_sh = high ? {wdata, {WORD_W{1'b0}}} : {{WORD_W{1'b0}}, wdata};
        wmask    = high ? {BANK_MASK, {WORD_W{1'b0}}} : {{WORD_W{1'b0}}, BANK_MASK};
        active   = (item.source_levels ^ {pol_high_reg, pol_low_reg}) & IMPL_MASK;

        status_next      = status_reg;
        enable_next      = enable_reg;
        prev_active_next = prev_active_reg;
        rd               = '0;

        case (item.operation)
            OP_SAMPLE:
            begin
                status_next = (status_reg | (active & ~prev_active_reg & enable_reg))
                              & IMPL_MASK;
                prev_active_next = active;
            end
            OP_READ:
            begin
                if (en_sel)
                begin
                    rd = high ? enable_reg[NUM_SRC-1:WORD_W] : enable_reg[WORD_W-1:0];
                end
                else
                begin
                    rd = high ? status_reg[NUM_SRC-1:WORD_W] : status_reg[WORD_W-1:0];
                end
                rd = rd & BANK_MASK;
            end
            OP_WRITE:
            begin
                if (en_sel)
                begin
                    enable_next = ((enable_reg & ~wmask) | wdata_sh) & IMPL_MASK;
                end
                else
                begin
                    status_next = status_reg & ~wdata_sh & IMPL_MASK;
                end
            end
            default:
            begin
                rd = '0;
            end
        endcase

        if (!item_accept)
        begin
            status_next      = status_reg;
            enable_next      = enable_reg;
            prev_active_next = prev_active_reg;
        end
    end

    // scan of the post-update status, one small encoder per group
    always_comb
    begin
        scan.read_data = rd;
        for (int g = 0; g < NUM_GRP; g++)
        begin
            scan.grp_any[g] = |status_next[g*GRP_W +: GRP_W];
            scan.grp_idx[g] = lowest_in_group(status_next[g*GRP_W +: GRP_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg      <= '0;
            enable_reg      <= '0;
            prev_active_reg <= '0;
            pol_low_reg     <= '0;
            pol_high_reg    <= '0;
        end
        else
        begin
            status_reg      <= status_next;
            enable_reg      <= enable_next;
            prev_active_reg <= prev_active_next;
            if (cfg_wr.valid)
            begin
                case (cfg_wr.index)
                    CFG_POL_LOW:  pol_low_reg  <= cfg_wr.data & BANK_MASK;
                    CFG_POL_HIGH: pol_high_reg <= cfg_wr.data & BANK_MASK;
                    default:      pol_low_reg  <= pol_low_reg;
                endcase
            end
        end
    end

endmodule

// ----- rtl/two_bank_edge_interrupt_controller_top.sv -----
// Top level of the two-bank edge interrupt controller: stream channels,
// configuration port and the two-register result pipeline.
// Depends on tbeic_pkg and tbeic_core.
//
// Usage
//   Slave stream: one transaction is a sample of all 64 source levels, a
//   register read or a register write, chosen by the operation code in
//   tuser. Sampling XORs levels with polarity; a rising active edge on an
//   enabled source sets its status bit. Status writes clear on ones,
//   enable writes load the selected bank word.
//   Master stream: exactly one result per input transaction, in order:
//   the read word (zero unless a read), the pending flag and the lowest
//   pending source, low bank first, as seen after the transaction.
//   Config port: polarity_low (index 0) and polarity_high (index 1); it is
//   always ready and should be written only while the block is idle.
// Timing
//   The result passes through the middle register and then the output
//   register. The state update and per-group scan sit before the first
//   register, the final group selection before the output register. One
//   transaction per cycle is sustained while the receiver accepts.
// Reset and stalls
//   rst_n clears all status, enable, edge history and polarity. When the
//   receiver stalls, the output register holds, then the middle register
//   fills, and s_axis_tready drops only once both are occupied.
module two_bank_edge_interrupt_controller_top
    import tbeic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // write_data[31:0], source_levels[95:32]
    input  logic [3:0]  s_axis_tuser,   // operation[1:0], reg_select[3:2]
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // read_data[31:0], irq_pending[32],
                                        // next_source[38:33], next_valid[39]
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    item_t   item;
    cfg_wr_t cfg_wr;
    scan_t   scan;

    logic    accept;
    logic    out_load;
    logic    s1_advance;

    logic    s1_valid_reg;
    scan_t   s1_reg;
    logic    m_valid_reg;
    logic [39:0] m_data_reg, m_data_next;

    assign item.operation     = s_axis_tuser[1:0];
    assign item.reg_select    = s_axis_tuser[3:2];
    assign item.write_data    = s_axis_tdata[WORD_W-1:0];
    assign item.source_levels = s_axis_tdata[WORD_W +: NUM_SRC];

    assign cfg_ready     = 1'b1;
    assign cfg_wr.valid  = cfg_valid & cfg_ready;
    assign cfg_wr.index  = cfg_index;
    assign cfg_wr.data   = cfg_data;

    // handshake: output frees, middle stage moves, input enters
    assign out_load      = !m_valid_reg || m_axis_tready;
    assign s1_advance    = s1_valid_reg && out_load;
    assign s_axis_tready = !s1_valid_reg || out_load;
    assign accept        = s_axis_tvalid && s_axis_tready;

    tbeic_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (accept),
        .item        (item),
        .cfg_wr      (cfg_wr),
        .scan        (scan)
    );

    // second level: pick the lowest non-empty group
    always_comb
    begin
        logic [SRC_IDX_W-1:0] src;
        src = '0;
        for (int g = NUM_GRP - 1; g >= 0; g--)
        begin
            if (s1_reg.grp_any[g])
            begin
                src = {GRP_IDX_W'(g), s1_reg.grp_idx[g]};
            end
        end
        m_data_next = {|s1_reg.grp_any, src, |s1_reg.grp_any, s1_reg.read_data};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= scan;
        end
        if (s1_advance)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ----- verif/two_bank_edge_interrupt_controller_top_tb.sv -----
// Self-checking testbench for the two-bank edge interrupt controller top level.
// Drives sample, read and write transactions and predicts every result in step.
// Depends on tbeic_pkg and the RTL of two_bank_edge_interrupt_controller_top.
module two_bank_edge_interrupt_controller_top_tb;
    import tbeic_pkg::*;

    // spare operation code: changes nothing, still reports status
    localparam logic [1:0] OP_SPARE = 2'd3;

    // register select values, as decoded by the bank and enable bits
    localparam logic [1:0] SEL_STATUS_LOW  = 2'd0;
    localparam logic [1:0] SEL_STATUS_HIGH = 2'd1;
    localparam logic [1:0] SEL_ENABLE_LOW  = 2'd2;
    localparam logic [1:0] SEL_ENABLE_HIGH = 2'd3;

    localparam int QUIET_LIMIT   = 2000;  // cycles with no transaction at all
    localparam int PRESSURE_HOLD = 300;   // long receiver hold-off
    localparam int PHASE_ITEMS   = 80;

    // one result as packed on m_axis_tdata, lowest field last
    typedef struct packed {
        logic              next_valid;
        logic [5:0]        next_source;
        logic              irq_pending;
        logic [WORD_W-1:0] read_data;
    } irq_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_POL_LOW;
    logic [31:0] cfg_data = '0;

    // shadow state of the controller
    logic [NUM_SRC-1:0] status_q;
    logic [NUM_SRC-1:0] enable_q;
    logic [NUM_SRC-1:0] active_hist_q;
    logic [WORD_W-1:0]  pol_low_q;
    logic [WORD_W-1:0]  pol_high_q;
    logic [NUM_SRC-1:0] last_levels;

    irq_report_t irq_reports_due[$];
    irq_report_t got_report;
    irq_report_t want_report;

    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int input_stall_cycles = 0;
    int mismatches = 0;
    int reports_checked = 0;
    int n_samples = 0;
    int n_reads = 0;
    int n_writes = 0;
    int n_spare = 0;
    int pol_settings = 0;

    two_bank_edge_interrupt_controller_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicts the result of one transaction and advances the shadow state.
    // Status fields reflect the state after the transaction has taken effect.
    function automatic irq_report_t predict_irq_report(input logic [1:0] op,
            input logic [1:0] sel, input logic [31:0] wdata, input logic [63:0] levels);
        irq_report_t        rep;
        logic [NUM_SRC-1:0] active;
        logic [NUM_SRC-1:0] word_mask;
        logic [NUM_SRC-1:0] data_wide;
        int                 shift;
        rep = '0;
        shift = sel[SEL_BANK_BIT] ? WORD_W : 0;
        data_wide = NUM_SRC'(wdata & BANK_MASK) << shift;
        word_mask = NUM_SRC'(BANK_MASK) << shift;
        case (op)
            OP_SAMPLE:
            begin
                active = (levels ^ {pol_high_q, pol_low_q}) & IMPL_MASK;
                // rising active edge on an enabled source latches status
                status_q = (status_q | (active & ~active_hist_q & enable_q)) & IMPL_MASK;
                active_hist_q = active;
            end
            OP_READ:
            begin
                if (sel[SEL_ENABLE_BIT])
                    rep.read_data = WORD_W'(enable_q >> shift) & BANK_MASK;
                else
                    rep.read_data = WORD_W'(status_q >> shift) & BANK_MASK;
            end
            OP_WRITE:
            begin
                if (sel[SEL_ENABLE_BIT])
                    enable_q = ((enable_q & ~word_mask) | data_wide) & IMPL_MASK;
                else
                    status_q = status_q & ~data_wide & IMPL_MASK;
            end
            default:
            begin
            end
        endcase
        rep.irq_pending = |status_q;
        // lowest pending source wins, low bank first
        for (int i = NUM_SRC - 1; i >= 0; i--)
        begin
            if (status_q[i])
            begin
                rep.next_source = 6'(i);
                rep.next_valid = 1'b1;
            end
        end
        return rep;
    endfunction

    // Offers one transaction, with random idle gaps before it, and records
    // the expected result once the block accepts it.
    task automatic send_item(input logic [1:0] op, input logic [1:0] sel,
            input logic [31:0] wdata, input logic [63:0] levels);
        @(negedge clk);
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata = {levels, wdata};
        s_axis_tuser = {sel, op};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        irq_reports_due.push_back(predict_irq_report(op, sel, wdata, levels));
        case (op)
            OP_SAMPLE:
            begin
                n_samples++;
                last_levels = levels;
            end
            OP_READ:  n_reads++;
            OP_WRITE: n_writes++;
            default:  n_spare++;
        endcase
    endtask

    // Stops offering and waits until every result is back and the pipe is empty.
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (irq_reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_polarity(input logic index, input logic [31:0] value);
        @(negedge clk);
        cfg_index = index;
        cfg_data = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == CFG_POL_LOW)
            pol_low_q = value & BANK_MASK;
        else
            pol_high_q = value & BANK_MASK;
        pol_settings++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_random_item();
        int         pick;
        logic [1:0] op;
        logic [1:0] sel;
        logic [31:0] wdata;
        logic [63:0] levels;
        pick = $urandom_range(99);
        if (pick < 50)
            op = OP_SAMPLE;
        else if (pick < 70)
            op = OP_READ;
        else if (pick < 94)
            op = OP_WRITE;
        else
            op = OP_SPARE;
        sel = 2'($urandom_range(3));
        case ($urandom_range(3))
            0:       wdata = '1;
            1:       wdata = 32'd1 << $urandom_range(31);
            default: wdata = $urandom;
        endcase
        // mix dense, sparse, single-toggle and fully inverted level patterns
        case ($urandom_range(3))
            0:       levels = {$urandom, $urandom};
            1:       levels = last_levels ^ (64'd1 << $urandom_range(63));
            2:       levels = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: levels = ~last_levels;
        endcase
        send_item(op, sel, wdata, levels);
    endtask

    // Reset values, the spare code, edges, W1C clearing and lost edges on
    // disabled sources.
    task automatic test_edges_and_clearing();
        send_item(OP_READ, SEL_STATUS_LOW, $urandom, {$urandom, $urandom});
        send_item(OP_READ, SEL_ENABLE_HIGH, $urandom, {$urandom, $urandom});
        send_item(OP_SPARE, SEL_ENABLE_LOW, $urandom, {$urandom, $urandom});
        send_item(OP_WRITE, SEL_ENABLE_LOW, '1, {$urandom, $urandom});
        send_item(OP_WRITE, SEL_ENABLE_HIGH, '1, {$urandom, $urandom});
        send_item(OP_SAMPLE, SEL_STATUS_LOW, $urandom, '0);
        send_item(OP_SAMPLE, SEL_ENABLE_HIGH, $urandom, '1);
        send_item(OP_READ, SEL_STATUS_HIGH, $urandom, '0);
        send_item(OP_WRITE, SEL_STATUS_LOW, '1, '0);
        send_item(OP_WRITE, SEL_STATUS_HIGH, 32'h7FFF_FFFF, '0);
        // levels stay high: no new edge
        send_item(OP_SAMPLE, SEL_STATUS_LOW, '0, '1);
        send_item(OP_WRITE, SEL_STATUS_HIGH, 32'h8000_0000, '1);
        send_item(OP_SAMPLE, SEL_STATUS_LOW, '0, '0);
        // edge on a disabled source is lost, not raised later on enable
        send_item(OP_WRITE, SEL_ENABLE_HIGH, '0, '0);
        send_item(OP_SAMPLE, SEL_STATUS_LOW, '0, (64'd1 << 40) | (64'd1 << 5));
        send_item(OP_WRITE, SEL_ENABLE_HIGH, '1, '0);
        send_item(OP_SAMPLE, SEL_STATUS_LOW, '0, (64'd1 << 40) | (64'd1 << 5));
        send_item(OP_READ, SEL_ENABLE_HIGH, '0, '1);
        send_item(OP_READ, SEL_ENABLE_LOW, '1, '1);
        send_item(OP_WRITE, SEL_STATUS_LOW, 32'h0000_0020, '1);
        send_item(OP_SPARE, SEL_ENABLE_HIGH, '1, '1);
        wait_idle();
    endtask

    // Polarity extremes; a polarity change with steady levels acts as an edge.
    task automatic test_polarity();
        write_polarity(CFG_POL_LOW, '1);
        write_polarity(CFG_POL_HIGH, '1);
        send_item(OP_SAMPLE, SEL_STATUS_LOW, '0, '1);
        send_item(OP_SAMPLE, SEL_STATUS_LOW, '0, '0);
        send_item(OP_WRITE, SEL_STATUS_LOW, '1, '0);
        send_item(OP_WRITE, SEL_STATUS_HIGH, '1, '0);
        wait_idle();
        write_polarity(CFG_POL_LOW, '0);
        write_polarity(CFG_POL_HIGH, '0);
        send_item(OP_SAMPLE, SEL_STATUS_LOW, '0, '0);
        wait_idle();
        write_polarity(CFG_POL_LOW, 32'h0000_FFFF);
        write_polarity(CFG_POL_HIGH, 32'h8000_0001);
        send_item(OP_SAMPLE, SEL_STATUS_LOW, '0, '0);
        send_item(OP_READ, SEL_STATUS_LOW, '0, '0);
        send_item(OP_READ, SEL_STATUS_HIGH, '0, '0);
        wait_idle();
    endtask

    task automatic test_random_phase(input int gap_pct, input int stall_pct);
        src_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        write_polarity(CFG_POL_LOW, $urandom);
        write_polarity(CFG_POL_HIGH, $urandom);
        repeat (PHASE_ITEMS) send_random_item();
        wait_idle();
    endtask

    // Receiver holds off for a long stretch while items keep coming, so the
    // pipe fills and the block has to stall its input.
    task automatic test_backpressure();
        src_gap_pct = 0;
        sink_stall_pct = 0;
        hold_request = PRESSURE_HOLD;
        repeat (60) send_random_item();
        wait_idle();
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            m_axis_tready = 1'b0;
            hold_left--;
        end
        else
        begin
            m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // result checker: every result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_report = m_axis_tdata;
            if (irq_reports_due.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want_report = irq_reports_due.pop_front();
                reports_checked++;
                if (got_report.read_data !== want_report.read_data)
                begin
                    $display("%0t read_data mismatch: expected %h, got %h",
                             $time, want_report.read_data, got_report.read_data);
                    mismatches++;
                end
                if (got_report.irq_pending !== want_report.irq_pending)
                begin
                    $display("%0t irq_pending mismatch: expected %b, got %b",
                             $time, want_report.irq_pending, got_report.irq_pending);
                    mismatches++;
                end
                if (got_report.next_source !== want_report.next_source)
                begin
                    $display("%0t next_source mismatch: expected %0d, got %0d",
                             $time, want_report.next_source, got_report.next_source);
                    mismatches++;
                end
                if (got_report.next_valid !== want_report.next_valid)
                begin
                    $display("%0t next_valid mismatch: expected %b, got %b",
                             $time, want_report.next_valid, got_report.next_valid);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: any transaction on any channel counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (s_axis_tvalid && !s_axis_tready)
                input_stall_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t watchdog: no transaction for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, irq_reports_due.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        status_q = '0;
        enable_q = '0;
        active_hist_q = '0;
        pol_low_q = '0;
        pol_high_q = '0;
        last_levels = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_edges_and_clearing();
        test_polarity();
        test_random_phase(0, 0);
        test_random_phase(60, 0);
        test_random_phase(0, 60);
        test_random_phase(22, 22);
        test_backpressure();
        write_polarity(CFG_POL_LOW, '0);
        write_polarity(CFG_POL_HIGH, '1);
        test_random_phase(0, 0);

        repeat (5) @(posedge clk);
        if (irq_reports_due.size() != 0)
        begin
            $display("%0t %0d expected results never arrived", $time, irq_reports_due.size());
            mismatches++;
        end
        $display("Covered %0d samples, %0d reads, %0d writes, %0d spare-code items; %0d results",
                 n_samples, n_reads, n_writes, n_spare, reports_checked);
        $display("checked across %0d polarity writes; input stalled for %0d cycles",
                 pol_settings, input_stall_cycles);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
